[rtl/tbpi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpi_pkg
// Shared types, constants and fixed-point helpers for the trackball pad port.
// ----------------------------------------------------------------------------
package tbpi_pkg;

  localparam int NUM_PADS      = 2;
  localparam int FRACTION_BITS = 8;
  localparam int PAD_IDX_W     = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

  localparam int CLK_W     = 48;
  localparam int TIMEOUT_W = 26;
  localparam int CPP_W     = 16;
  localparam int UNK_W     = 27;
  localparam int IDLE_W    = 10;
  localparam int MOTION_W  = 16;

  // serial divider of the absolute phase count
  localparam int DIV_NUM_W = CLK_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam logic [IDLE_W-1:0]    RELATIVE_IDLE_LIMIT = 10'd512;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET       = 26'd10738635;
  localparam logic [CPP_W-1:0]     CPP_RESET           = 16'd170;
  localparam logic [3:0]           PHASE_COUNT         = 4'd5;
  localparam logic [7:0]           ABS_HEADER          = 8'h34;
  localparam logic [7:0]           ABS_LOW_TAG         = 8'h10;
  localparam logic [7:0]           NIBBLE_MASK         = 8'h0F;
  localparam logic signed [MOTION_W-1:0] REL_MIN       = -16'sd127;
  localparam logic signed [MOTION_W-1:0] REL_MAX       = 16'sd128;

  typedef enum logic [1:0] {
    MODE_UNKNOWN  = 2'd0,
    MODE_RELATIVE = 2'd1,
    MODE_ABSOLUTE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    FUNC_SYNC = 2'd0,
    FUNC_TH   = 2'd1,
    FUNC_MOVE = 2'd2,
    FUNC_READ = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    REG_PAD_ENABLED  = 2'd0,
    REG_MODE_TIMEOUT = 2'd1,
    REG_CYCLES_PHASE = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ELAPSE,
    ST_MODE,
    ST_DIV,
    ST_DIV_DONE,
    ST_APPLY,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic load_in;
    logic elapse;
    logic mode_upd;
    logic div_step;
    logic div_done;
    logic apply;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_sync;
    logic clk_back;
    logic is_abs;
    logic div_last;
    logic out_free;
  } dp_status_t;

  // whole part of a fixed-point value, truncated towards zero
  function automatic logic signed [MOTION_W-1:0] whole_part(
    input logic signed [MOTION_W-1:0] v
  );
    logic signed [MOTION_W-1:0] w;
    w = v >>> FRACTION_BITS;
    if (v[MOTION_W-1] && (v[FRACTION_BITS-1:0] != '0)) begin
      w = w + 16'sd1;
    end
    return w;
  endfunction

  // whole part clamped to the relative delta range
  function automatic logic signed [MOTION_W-1:0] rel_whole(
    input logic signed [MOTION_W-1:0] v
  );
    logic signed [MOTION_W-1:0] w;
    w = whole_part(v);
    if (w < REL_MIN) begin
      w = REL_MIN;
    end else if (w > REL_MAX) begin
      w = REL_MAX;
    end
    return w;
  endfunction

  // saturating signed add
  function automatic logic signed [MOTION_W-1:0] sat_add(
    input logic signed [MOTION_W-1:0] a,
    input logic signed [MOTION_W-1:0] b
  );
    logic signed [MOTION_W:0] s;
    s = {a[MOTION_W-1], a} + {b[MOTION_W-1], b};
    if (s[MOTION_W] != s[MOTION_W-1]) begin
      return s[MOTION_W] ? {1'b1, {(MOTION_W-1){1'b0}}} : {1'b0, {(MOTION_W-1){1'b1}}};
    end
    return s[MOTION_W-1:0];
  endfunction

endpackage

[rtl/tbpi_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpi_controller
// Sequencer for one event: clock sync, phase divide, event apply, result.
// ----------------------------------------------------------------------------
module tbpi_controller (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tbpi_pkg::dp_status_t  status_i,
  output tbpi_pkg::ctrl_cmd_t   cmd_o
);

  tbpi_pkg::ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tbpi_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tbpi_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tbpi_pkg::ST_ELAPSE;
      end
      tbpi_pkg::ST_ELAPSE: begin
        if (!status_i.need_sync || status_i.clk_back) state_d = tbpi_pkg::ST_APPLY;
        else state_d = tbpi_pkg::ST_MODE;
      end
      tbpi_pkg::ST_MODE: begin
        if (status_i.is_abs) state_d = tbpi_pkg::ST_DIV;
        else state_d = tbpi_pkg::ST_APPLY;
      end
      tbpi_pkg::ST_DIV: begin
        if (status_i.div_last) state_d = tbpi_pkg::ST_DIV_DONE;
      end
      tbpi_pkg::ST_DIV_DONE: state_d = tbpi_pkg::ST_APPLY;
      tbpi_pkg::ST_APPLY:    state_d = tbpi_pkg::ST_OUT;
      tbpi_pkg::ST_OUT: begin
        if (status_i.out_free) state_d = tbpi_pkg::ST_IDLE;
      end
      default: state_d = tbpi_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      tbpi_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      tbpi_pkg::ST_ELAPSE:   cmd_o.elapse   = status_i.need_sync;
      tbpi_pkg::ST_MODE:     cmd_o.mode_upd = 1'b1;
      tbpi_pkg::ST_DIV:      cmd_o.div_step = 1'b1;
      tbpi_pkg::ST_DIV_DONE: cmd_o.div_done = 1'b1;
      tbpi_pkg::ST_APPLY:    cmd_o.apply    = 1'b1;
      tbpi_pkg::ST_OUT:      cmd_o.load_out = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

[rtl/tbpi_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpi_datapath
// Pad state, configuration registers, serial phase divider and result register.
// ----------------------------------------------------------------------------
module tbpi_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_valid_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [25:0]           cfg_data_i,
  // event fields
  input  logic [1:0]            func_i,
  input  logic                  pad_select_i,
  input  logic [47:0]           master_clock_i,
  input  logic                  th_level_i,
  input  logic signed [15:0]    move_x_i,
  input  logic signed [15:0]    move_y_i,
  input  logic [1:0]            buttons_i,
  // control
  input  tbpi_pkg::ctrl_cmd_t   cmd_i,
  output tbpi_pkg::dp_status_t  status_o,
  // result
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            read_data_o,
  output logic [1:0]            pad_mode_o
);

  localparam int NP = tbpi_pkg::NUM_PADS;
  localparam int PW = tbpi_pkg::PAD_IDX_W;
  localparam int F  = tbpi_pkg::FRACTION_BITS;

  // latched event
  tbpi_pkg::func_e   func_q;
  logic [PW-1:0]     idx_q;
  logic [47:0]       clk_q;
  logic              th_q;
  logic signed [15:0] mvx_q, mvy_q;
  logic [1:0]        btn_q;
  logic [PW-1:0]     idx_d;

  // configuration
  logic [1:0]  pad_enabled_q;
  logic [25:0] timeout_q;
  logic [15:0] cpp_q;

  // per-pad state
  logic [47:0]        last_q   [NP];
  tbpi_pkg::mode_e    mode_q   [NP];
  logic               th_lvl_q [NP];
  logic signed [15:0] px_q     [NP];
  logic signed [15:0] py_q     [NP];
  logic [7:0]         posx_q   [NP];
  logic [7:0]         posy_q   [NP];
  logic [7:0]         dx_q     [NP];
  logic [7:0]         dy_q     [NP];
  logic [1:0]         rstep_q  [NP];
  logic [2:0]         astep_q  [NP];
  logic [15:0]        phase_q  [NP];
  logic [26:0]        unk_q    [NP];
  logic [9:0]         idle_q   [NP];

  // sync and divider work registers
  logic [47:0]                        elapsed_q;
  logic [tbpi_pkg::DIV_NUM_W-1:0]     div_num_q;
  logic [15:0]                        div_rem_q;
  logic [2:0]                         div_q5_q;
  logic [tbpi_pkg::DIV_CNT_W-1:0]     div_cnt_q;

  // result register
  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic [1:0] out_mode_q;

  // selected pad index, out-of-range selects pad 0
  always_comb begin
    if (32'(pad_select_i) < NP) idx_d = PW'(pad_select_i);
    else idx_d = '0;
  end

  // status towards the controller
  logic en;
  logic [15:0] cpp_eff;
  assign en = (32'(idx_q) < 2) ? pad_enabled_q[idx_q[0]] : 1'b0;
  assign cpp_eff = (cpp_q == '0) ? 16'd1 : cpp_q;

  assign status_o.need_sync = (func_q == tbpi_pkg::FUNC_SYNC) ||
                              (func_q == tbpi_pkg::FUNC_READ) ||
                              (en && ((func_q == tbpi_pkg::FUNC_MOVE) ||
                                      ((func_q == tbpi_pkg::FUNC_TH) &&
                                       (th_lvl_q[idx_q] != th_q))));
  assign status_o.clk_back  = clk_q < last_q[idx_q];
  assign status_o.is_abs    = mode_q[idx_q] == tbpi_pkg::MODE_ABSOLUTE;
  assign status_o.div_last  = div_cnt_q == tbpi_pkg::DIV_CNT_W'(tbpi_pkg::DIV_NUM_W - 1);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // saturating counters of the sync
  logic [27:0] unk_sum;
  logic [26:0] unk_new;
  logic [10:0] idle_sum;
  logic [9:0]  idle_new;
  assign unk_sum  = {1'b0, unk_q[idx_q]} + {1'b0, elapsed_q[26:0]};
  assign unk_new  = ((elapsed_q[47:27] != '0) || unk_sum[27]) ? '1 : unk_sum[26:0];
  assign idle_sum = {1'b0, idle_q[idx_q]} + {1'b0, elapsed_q[9:0]};
  assign idle_new = ((elapsed_q[47:10] != '0) || idle_sum[10]) ? '1 : idle_sum[9:0];

  // absolute drain of the stored pending motion
  logic signed [15:0] wx, wy;
  assign wx = tbpi_pkg::whole_part(px_q[idx_q]);
  assign wy = tbpi_pkg::whole_part(py_q[idx_q]);

  // movement sum and its absolute drain
  logic signed [15:0] sx, sy, swx, swy;
  assign sx  = tbpi_pkg::sat_add(px_q[idx_q], mvx_q);
  assign sy  = tbpi_pkg::sat_add(py_q[idx_q], mvy_q);
  assign swx = tbpi_pkg::whole_part(sx);
  assign swy = tbpi_pkg::whole_part(sy);

  // relative drain
  logic signed [15:0] rwx, rwy;
  assign rwx = tbpi_pkg::rel_whole(px_q[idx_q]);
  assign rwy = tbpi_pkg::rel_whole(py_q[idx_q]);

  // divider step, quotient kept modulo five
  logic [16:0] div_sh;
  logic        div_ge;
  logic [3:0]  q5_t;
  logic [2:0]  q5_d;
  logic [15:0] rem_d;
  assign div_sh = {div_rem_q, div_num_q[tbpi_pkg::DIV_NUM_W-1]};
  assign div_ge = div_sh >= {1'b0, cpp_eff};
  assign rem_d  = div_ge ? 16'(div_sh - {1'b0, cpp_eff}) : div_sh[15:0];
  assign q5_t   = {div_q5_q, 1'b0} + {3'b000, div_ge};
  assign q5_d   = (q5_t >= tbpi_pkg::PHASE_COUNT) ?
                  3'(q5_t - tbpi_pkg::PHASE_COUNT) : q5_t[2:0];

  logic [3:0] astep_sum;
  logic [2:0] astep_new;
  assign astep_sum = {1'b0, astep_q[idx_q]} + {1'b0, div_q5_q};
  assign astep_new = (astep_sum >= tbpi_pkg::PHASE_COUNT) ?
                     3'(astep_sum - tbpi_pkg::PHASE_COUNT) : astep_sum[2:0];

  // relative read-phase step for a TH edge
  logic [1:0] step_eff, rstep_new;
  logic       idle_over;
  always_comb begin
    if (mode_q[idx_q] == tbpi_pkg::MODE_UNKNOWN) begin
      step_eff  = 2'd3;
      idle_over = 1'b1;
    end else begin
      step_eff  = rstep_q[idx_q];
      idle_over = idle_q[idx_q] > tbpi_pkg::RELATIVE_IDLE_LIMIT;
    end
    if (!th_q) begin
      if (idle_over || step_eff == 2'd3) rstep_new = 2'd0;
      else if (step_eff == 2'd1) rstep_new = 2'd2;
      else rstep_new = 2'd0;
    end else begin
      if (step_eff == 2'd0) rstep_new = 2'd1;
      else if (step_eff == 2'd2) rstep_new = 2'd3;
      else rstep_new = step_eff;
    end
  end

  // result byte of a port read
  logic [7:0] hi, data_d;
  assign hi = {2'b00, btn_q, 4'b0000};
  always_comb begin
    data_d = '0;
    if (func_q == tbpi_pkg::FUNC_READ) begin
      case (mode_q[idx_q])
        tbpi_pkg::MODE_RELATIVE: begin
          case (rstep_q[idx_q])
            2'd0:    data_d = hi | {4'h0, dx_q[idx_q][7:4]};
            2'd1:    data_d = hi | (dx_q[idx_q] & tbpi_pkg::NIBBLE_MASK);
            2'd2:    data_d = hi | {4'h0, dy_q[idx_q][7:4]};
            default: data_d = hi | (dy_q[idx_q] & tbpi_pkg::NIBBLE_MASK);
          endcase
        end
        tbpi_pkg::MODE_ABSOLUTE: begin
          case (astep_q[idx_q])
            3'd0:    data_d = tbpi_pkg::ABS_HEADER | {6'd0, btn_q};
            3'd1:    data_d = {4'h0, posx_q[idx_q][7:4]};
            3'd2:    data_d = tbpi_pkg::ABS_LOW_TAG | (posx_q[idx_q] & tbpi_pkg::NIBBLE_MASK);
            3'd3:    data_d = {4'h0, posy_q[idx_q][7:4]};
            default: data_d = tbpi_pkg::ABS_LOW_TAG | (posy_q[idx_q] & tbpi_pkg::NIBBLE_MASK);
          endcase
        end
        default: data_d = hi | tbpi_pkg::NIBBLE_MASK;
      endcase
    end
  end

  // event latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q <= tbpi_pkg::func_e'(func_i);
      idx_q  <= idx_d;
      clk_q  <= master_clock_i;
      th_q   <= th_level_i;
      mvx_q  <= move_x_i;
      mvy_q  <= move_y_i;
      btn_q  <= buttons_i;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_enabled_q <= '0;
      timeout_q     <= tbpi_pkg::TIMEOUT_RESET;
      cpp_q         <= tbpi_pkg::CPP_RESET;
    end else if (cfg_valid_i) begin
      case (tbpi_pkg::reg_idx_e'(cfg_index_i))
        tbpi_pkg::REG_PAD_ENABLED:  pad_enabled_q <= cfg_data_i[1:0];
        tbpi_pkg::REG_MODE_TIMEOUT: timeout_q     <= cfg_data_i;
        tbpi_pkg::REG_CYCLES_PHASE: cpp_q         <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // divider and elapsed registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.elapse) begin
      elapsed_q <= clk_q - last_q[idx_q];
    end
    if (cmd_i.mode_upd) begin
      div_num_q <= {1'b0, elapsed_q} + {33'd0, phase_q[idx_q]};
      div_rem_q <= '0;
      div_q5_q  <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_num_q <= {div_num_q[tbpi_pkg::DIV_NUM_W-2:0], 1'b0};
      div_rem_q <= rem_d;
      div_q5_q  <= q5_d;
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  // per-pad state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NP; i++) begin
        last_q[i]   <= '0;
        mode_q[i]   <= tbpi_pkg::MODE_UNKNOWN;
        th_lvl_q[i] <= 1'b1;
        px_q[i]     <= '0;
        py_q[i]     <= '0;
        posx_q[i]   <= '0;
        posy_q[i]   <= '0;
        dx_q[i]     <= '0;
        dy_q[i]     <= '0;
        rstep_q[i]  <= 2'd3;
        astep_q[i]  <= '0;
        phase_q[i]  <= '0;
        unk_q[i]    <= '0;
        idle_q[i]   <= '0;
      end
    end else begin
      // an enable change returns the pad to reset, keeping its clock
      if (cfg_valid_i && (tbpi_pkg::reg_idx_e'(cfg_index_i) == tbpi_pkg::REG_PAD_ENABLED)) begin
        for (int i = 0; i < NP && i < 2; i++) begin
          if (cfg_data_i[i] != pad_enabled_q[i]) begin
            mode_q[i]   <= tbpi_pkg::MODE_UNKNOWN;
            th_lvl_q[i] <= 1'b1;
            px_q[i]     <= '0;
            py_q[i]     <= '0;
            posx_q[i]   <= '0;
            posy_q[i]   <= '0;
            dx_q[i]     <= '0;
            dy_q[i]     <= '0;
            rstep_q[i]  <= 2'd3;
            astep_q[i]  <= '0;
            phase_q[i]  <= '0;
            unk_q[i]    <= '0;
            idle_q[i]   <= '0;
          end
        end
      end

      // clock step
      if (cmd_i.elapse) begin
        last_q[idx_q] <= clk_q;
      end

      // mode bookkeeping of the sync
      if (cmd_i.mode_upd) begin
        case (mode_q[idx_q])
          tbpi_pkg::MODE_UNKNOWN: begin
            unk_q[idx_q] <= unk_new;
            if (unk_new >= {1'b0, timeout_q}) begin
              mode_q[idx_q]  <= tbpi_pkg::MODE_ABSOLUTE;
              astep_q[idx_q] <= '0;
              phase_q[idx_q] <= '0;
              px_q[idx_q]    <= px_q[idx_q] - (wx <<< F);
              py_q[idx_q]    <= py_q[idx_q] - (wy <<< F);
              posx_q[idx_q]  <= posx_q[idx_q] + wx[7:0];
              posy_q[idx_q]  <= posy_q[idx_q] + wy[7:0];
            end
          end
          tbpi_pkg::MODE_RELATIVE: idle_q[idx_q] <= idle_new;
          default: ;
        endcase
      end

      // end of the absolute phase divide
      if (cmd_i.div_done) begin
        astep_q[idx_q] <= astep_new;
        phase_q[idx_q] <= div_rem_q;
        px_q[idx_q]    <= px_q[idx_q] - (wx <<< F);
        py_q[idx_q]    <= py_q[idx_q] - (wy <<< F);
        posx_q[idx_q]  <= posx_q[idx_q] + wx[7:0];
        posy_q[idx_q]  <= posy_q[idx_q] + wy[7:0];
      end

      // event action
      if (cmd_i.apply) begin
        case (func_q)
          tbpi_pkg::FUNC_TH: begin
            if (en && (th_lvl_q[idx_q] != th_q)) begin
              th_lvl_q[idx_q] <= th_q;
              if (mode_q[idx_q] != tbpi_pkg::MODE_ABSOLUTE) begin
                mode_q[idx_q]  <= tbpi_pkg::MODE_RELATIVE;
                rstep_q[idx_q] <= rstep_new;
                idle_q[idx_q]  <= '0;
                if (!th_q && (rstep_new == 2'd0)) begin
                  px_q[idx_q] <= px_q[idx_q] - (rwx <<< F);
                  py_q[idx_q] <= py_q[idx_q] - (rwy <<< F);
                  dx_q[idx_q] <= 8'(16'sd0 - rwx);
                  dy_q[idx_q] <= 8'(16'sd0 - rwy);
                end
              end
            end
          end
          tbpi_pkg::FUNC_MOVE: begin
            if (en) begin
              if (mode_q[idx_q] == tbpi_pkg::MODE_ABSOLUTE) begin
                px_q[idx_q]   <= sx - (swx <<< F);
                py_q[idx_q]   <= sy - (swy <<< F);
                posx_q[idx_q] <= posx_q[idx_q] + swx[7:0];
                posy_q[idx_q] <= posy_q[idx_q] + swy[7:0];
              end else begin
                px_q[idx_q] <= sx;
                py_q[idx_q] <= sy;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= data_d;
      out_mode_q <= mode_q[idx_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign pad_mode_o  = out_mode_q;

endmodule

[rtl/trackball_pad_port_interface.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trackball_pad_port_interface
// Two trackball pads behind a controller port, stepped by port events.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one event per transfer: tuser holds func and pad_select,
//   tdata holds master_clock, th_level, move_x, move_y and buttons.
//   m_axis returns one result per event: read_data and pad_mode.
//   The cfg channel writes pad_enabled, mode_timeout_cycles and cycles_per_phase;
//   it is always ready; the user must write it only while idle (not enforced).
// Sequence:
//   an event passes through elapse, mode, apply and out; the mode state is skipped
//   when the pad needs no sync or its clock goes backwards. When the selected pad
//   is in absolute mode, a one-bit-per-cycle divide of the elapsed cycles by the
//   phase length runs after mode and before apply. One event is handled at a time.
// Reset:
//   rst_ni clears both pads to unknown mode with TH high and restores the
//   register defaults; no clearing pass is needed.
// Stall:
//   the result sits in an output register; the next event is taken while it
//   waits, and that event's result is held back until the first is taken.
// ----------------------------------------------------------------------------
module trackball_pad_port_interface (
  input  logic         clk_i,
  input  logic         rst_ni,
  // event stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [87:0]  s_axis_tdata_i,  // master_clock, th_level, move_x, move_y, buttons
  input  logic [2:0]   s_axis_tuser_i,  // func, pad_select
  // result stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [15:0]  m_axis_tdata_o,  // read_data, pad_mode
  // configuration writes
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [25:0]  cfg_data_i
);

  tbpi_pkg::ctrl_cmd_t  cmd;
  tbpi_pkg::dp_status_t status;
  logic [7:0]           read_data;
  logic [1:0]           pad_mode;

  assign cfg_ready_o = 1'b1;

  // sequencer
  tbpi_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // pad state and arithmetic
  tbpi_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .func_i         (s_axis_tuser_i[1:0]),
    .pad_select_i   (s_axis_tuser_i[2]),
    .master_clock_i (s_axis_tdata_i[47:0]),
    .th_level_i     (s_axis_tdata_i[48]),
    .move_x_i       (s_axis_tdata_i[64:49]),
    .move_y_i       (s_axis_tdata_i[80:65]),
    .buttons_i      (s_axis_tdata_i[82:81]),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .read_data_o    (read_data),
    .pad_mode_o     (pad_mode)
  );

  assign m_axis_tdata_o = {6'd0, pad_mode, read_data};

endmodule

[rtl/tbpi_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpi_checker
// Port-level checks of the trackball pad port, bound to the top level.
// ----------------------------------------------------------------------------
module tbpi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // reported mode is one of the three modes
  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[9:8] != 2'd3)
    else $error("invalid pad mode");

  // one event at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("event taken while busy");

  // no result in the cycle after a transfer in
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !$rose(m_axis_tvalid_o))
    else $error("result too early");

endmodule

bind trackball_pad_port_interface tbpi_checker u_tbpi_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
